// ----- rtl/cgap_pkg.sv -----
// Shared types, codes and constants for the CJK glyph address parser.
package cgap_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned CFG_W  = 24;

  localparam logic [15:0] MAP_FIRST_CODE = 16'd19968;
  localparam logic [15:0] MAP_LAST_CODE  = 16'd40869;

  localparam logic [LEN_W-1:0] SMALL_GLYPH_BYTES = 6'd24;
  localparam logic [LEN_W-1:0] MID_GLYPH_BYTES   = 6'd32;
  localparam logic [LEN_W-1:0] LARGE_GLYPH_BYTES = 6'd60;
  localparam logic [LEN_W-1:0] MAP_ENTRY_BYTES   = 6'd2;

  localparam logic [7:0]        UTF_LEAD_MASK = 8'hF0;
  localparam logic [7:0]        UTF_LEAD_CODE = 8'hE0;
  localparam logic [7:0]        GB_FIRST_BYTE = 8'hA1;
  localparam logic [ADDR_W-1:0] GB_ROW_LEN    = 24'd94;
  localparam logic [7:0]        SIZE_SMALL    = 8'd12;
  localparam logic [7:0]        SIZE_LARGE    = 8'd20;

  // input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TEXT  = 2'd1,
    OP_MAP   = 2'd2
  } op_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_GLYPH = 3'd0,
    KIND_ASCII = 3'd1,
    KIND_MAP   = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CJK_SIZE    = 3'd0,
    CFG_ASCII_SIZE  = 3'd1,
    CFG_MIXED       = 3'd2,
    CFG_MAP_BASE    = 3'd3,
    CFG_FONT12_BASE = 3'd4,
    CFG_FONT16_BASE = 3'd5,
    CFG_FONT20_BASE = 3'd6
  } cfg_idx_e;

  // parser phase; GLYPH is the address multiply step
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UTF1,
    ST_UTF2,
    ST_MAPW,
    ST_GB1,
    ST_GLYPH
  } phase_e;

  typedef struct packed {
    logic  load_pen;
    logic  save_first;
    logic  save_second;
    logic  calc_idx;
    logic  idx_from_map;
    logic  emit;
    kind_e emit_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       byte_zero;
    logic       utf_lead;
    logic       gb_lead;
    logic       code_ok;
    logic       word_zero;
    logic       mixed;
  } status_t;

endpackage

// ----- rtl/cgap_ctrl.sv -----
// Parser state machine and handshake control.
module cgap_ctrl import cgap_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  phase_e phase_q, phase_d;
  logic   stopped_q, stopped_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   live;

  assign in_stall_o  = (phase_q == ST_GLYPH) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign live        = accept && !stopped_q;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    stopped_d = stopped_q;
    if (phase_q == ST_GLYPH) begin
      phase_d = ST_IDLE;
    end else if (accept && status_i.op == OP_START) begin
      phase_d   = ST_IDLE;
      stopped_d = 1'b0;
    end else if (live && status_i.op == OP_MAP) begin
      if (phase_q == ST_MAPW) begin
        if (status_i.word_zero) begin
          phase_d   = ST_IDLE;
          stopped_d = 1'b1;
        end else begin
          phase_d = ST_GLYPH;
        end
      end
    end else if (live && status_i.op == OP_TEXT) begin
      if (status_i.byte_zero && phase_q != ST_MAPW) begin
        phase_d   = ST_IDLE;
        stopped_d = 1'b1;
      end else begin
        unique case (phase_q)
          ST_IDLE: begin
            if (status_i.utf_lead) begin
              phase_d = ST_UTF1;
            end else if (status_i.gb_lead) begin
              phase_d = ST_GB1;
            end
          end
          ST_UTF1: phase_d = ST_UTF2;
          ST_UTF2: begin
            if (status_i.code_ok) begin
              phase_d = ST_MAPW;
            end else begin
              phase_d   = ST_IDLE;
              stopped_d = 1'b1;
            end
          end
          ST_GB1:  phase_d = ST_GLYPH;
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = KIND_END;
    if (phase_q == ST_GLYPH) begin
      cmd_o.emit      = 1'b1;
      cmd_o.emit_kind = KIND_GLYPH;
    end else if (accept && status_i.op == OP_START) begin
      cmd_o.load_pen = 1'b1;
    end else if (live && status_i.op == OP_MAP) begin
      if (phase_q == ST_MAPW) begin
        if (status_i.word_zero) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_ERROR;
        end else begin
          cmd_o.calc_idx     = 1'b1;
          cmd_o.idx_from_map = 1'b1;
        end
      end
    end else if (live && status_i.op == OP_TEXT) begin
      if (status_i.byte_zero && phase_q != ST_MAPW) begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_END;
      end else begin
        unique case (phase_q)
          ST_IDLE: begin
            if (status_i.utf_lead || status_i.gb_lead) begin
              cmd_o.save_first = 1'b1;
            end else if (status_i.mixed) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_ASCII;
            end
          end
          ST_UTF1: cmd_o.save_second = 1'b1;
          ST_UTF2: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = status_i.code_ok ? KIND_MAP : KIND_ERROR;
          end
          ST_GB1:  cmd_o.calc_idx = 1'b1;
          default: cmd_o.emit = 1'b0;
        endcase
      end
    end
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ST_IDLE;
      stopped_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/cgap_dp.sv -----
// Datapath: configuration registers, pen, byte store, address arithmetic, result register.
module cgap_dp import cgap_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]          operation_i,
  input  logic signed [15:0]  start_x_i,
  input  logic signed [15:0]  start_y_i,
  input  logic [7:0]          text_byte_i,
  input  logic [15:0]         map_word_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [2:0]          kind_o,
  output logic [ADDR_W-1:0]   flash_address_o,
  output logic [LEN_W-1:0]    read_length_o,
  output logic signed [15:0]  draw_x_o,
  output logic signed [15:0]  draw_y_o,
  output logic [7:0]          glyph_size_o,
  output logic [7:0]          char_code_o
);

  logic [7:0]        cjk_size_q, ascii_size_q;
  logic              mixed_q;
  logic [ADDR_W-1:0] map_base_q, font12_q, font16_q, font20_q;

  logic [7:0]        first_q, second_q;
  logic [15:0]       pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic [15:0]       code;
  logic [15:0]       code_ofs;
  logic [ADDR_W-1:0] map_addr;
  logic [7:0]        hi_sel, lo_sel;
  logic [ADDR_W-1:0] row, col;
  logic [ADDR_W-1:0] font_base;
  logic [LEN_W-1:0]  glyph_bytes;
  logic [ADDR_W-1:0] glyph_addr;

  logic [2:0]        kind_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  len_q;
  logic [15:0]       dx_q, dy_q;
  logic [7:0]        size_q, code_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cjk_size_q   <= 8'd16;
      ascii_size_q <= 8'd8;
      mixed_q      <= 1'b1;
      map_base_q   <= '0;
      font12_q     <= '0;
      font16_q     <= '0;
      font20_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CJK_SIZE:    cjk_size_q   <= cfg_data_i[7:0];
        CFG_ASCII_SIZE:  ascii_size_q <= cfg_data_i[7:0];
        CFG_MIXED:       mixed_q      <= cfg_data_i[0];
        CFG_MAP_BASE:    map_base_q   <= cfg_data_i;
        CFG_FONT12_BASE: font12_q     <= cfg_data_i;
        CFG_FONT16_BASE: font16_q     <= cfg_data_i;
        CFG_FONT20_BASE: font20_q     <= cfg_data_i;
        default:         mixed_q      <= mixed_q;
      endcase
    end
  end

  // status towards the controller
  assign code     = {first_q[3:0], second_q[5:0], text_byte_i[5:0]};
  assign code_ofs = code - MAP_FIRST_CODE;
  assign map_addr = map_base_q + {7'd0, code_ofs, 1'b0};

  assign status_o.op        = operation_i;
  assign status_o.byte_zero = (text_byte_i == 8'd0);
  assign status_o.utf_lead  = ((text_byte_i & UTF_LEAD_MASK) == UTF_LEAD_CODE);
  assign status_o.gb_lead   = (text_byte_i >= GB_FIRST_BYTE);
  assign status_o.code_ok   = (code >= MAP_FIRST_CODE) && (code <= MAP_LAST_CODE);
  assign status_o.word_zero = (map_word_i == 16'd0);
  assign status_o.mixed     = mixed_q;

  // glyph index: row * 94 + col, wrapping, registered in idx_q
  assign hi_sel = cmd_i.idx_from_map ? map_word_i[15:8] : first_q;
  assign lo_sel = cmd_i.idx_from_map ? map_word_i[7:0]  : text_byte_i;
  assign row    = {16'd0, hi_sel} - {16'd0, GB_FIRST_BYTE};
  assign col    = {16'd0, lo_sel} - {16'd0, GB_FIRST_BYTE};
  assign idx_d  = cmd_i.calc_idx ? (row * GB_ROW_LEN) + col : idx_q;

  // glyph address from the registered index
  always_comb begin
    if (cjk_size_q == SIZE_SMALL) begin
      font_base   = font12_q;
      glyph_bytes = SMALL_GLYPH_BYTES;
    end else if (cjk_size_q == SIZE_LARGE) begin
      font_base   = font20_q;
      glyph_bytes = LARGE_GLYPH_BYTES;
    end else begin
      font_base   = font16_q;
      glyph_bytes = MID_GLYPH_BYTES;
    end
  end

  assign glyph_addr = font_base + (idx_q * {{(ADDR_W-LEN_W){1'b0}}, glyph_bytes});

  // pen
  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (cmd_i.load_pen) begin
      pen_x_d = start_x_i;
      pen_y_d = start_y_i;
    end else if (cmd_i.emit && cmd_i.emit_kind == KIND_GLYPH) begin
      pen_x_d = pen_x_q + {8'd0, cjk_size_q};
    end else if (cmd_i.emit && cmd_i.emit_kind == KIND_ASCII) begin
      pen_x_d = pen_x_q + {8'd0, ascii_size_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      pen_x_q  <= '0;
      pen_y_q  <= '0;
    end else begin
      if (cmd_i.save_first) begin
        first_q <= text_byte_i;
      end
      if (cmd_i.save_second) begin
        second_q <= text_byte_i;
      end
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

  // result register; fields not used by a kind read zero
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.emit) begin
      kind_q <= cmd_i.emit_kind;
      unique case (cmd_i.emit_kind)
        KIND_GLYPH: begin
          addr_q <= glyph_addr;
          len_q  <= glyph_bytes;
          dx_q   <= pen_x_q;
          dy_q   <= pen_y_q;
          size_q <= cjk_size_q;
          code_q <= '0;
        end
        KIND_ASCII: begin
          addr_q <= '0;
          len_q  <= '0;
          dx_q   <= pen_x_q;
          dy_q   <= pen_y_q;
          size_q <= ascii_size_q;
          code_q <= text_byte_i;
        end
        KIND_MAP: begin
          addr_q <= map_addr;
          len_q  <= MAP_ENTRY_BYTES;
          dx_q   <= '0;
          dy_q   <= '0;
          size_q <= '0;
          code_q <= '0;
        end
        default: begin
          addr_q <= '0;
          len_q  <= '0;
          dx_q   <= '0;
          dy_q   <= '0;
          size_q <= '0;
          code_q <= '0;
        end
      endcase
    end
  end

  assign kind_o          = kind_q;
  assign flash_address_o = addr_q;
  assign read_length_o   = len_q;
  assign draw_x_o        = $signed(dx_q);
  assign draw_y_o        = $signed(dy_q);
  assign glyph_size_o    = size_q;
  assign char_code_o     = code_q;

endmodule

// ----- rtl/cjk_glyph_address_parser.sv -----
// Top level of the CJK glyph address parser: controller plus datapath.
//
// Usage
//  - Input channel (in_valid_i / in_stall_o): one beat is a start item, a text
//    byte or a map reply, chosen by operation_i. A start item loads the pen and
//    re-arms the parser; it gives no result.
//  - Output channel (out_valid_o / out_stall_i): at most one result beat per
//    input beat: glyph read, ASCII draw, map read, end or error stop.
//  - After a map read result the host fetches the two-byte entry and returns it
//    as a map reply beat, which then gives the glyph read.
//  - A result appears in the cycle after its input beat is taken, but a glyph
//    read first registers row * 94 + col, then base + index * glyph bytes.
//  - Throughput: one beat a cycle while the output is not stalled; the GLYPH
//    phase after an item that completes a glyph also stalls the input.
//  - The result register parts the two sides; while a result waits under a
//    stall the input is stalled as well, and nothing is lost or repeated.
//  - Reset: configuration returns to its defaults, the pen to zero, and the
//    string is stopped until the first start item. No clearing pass.
//  - Configuration (cfg_we_i, cfg_index_i, cfg_data_i) is to be written by the
//    user only while idle; the block itself does not enforce this.
module cjk_glyph_address_parser import cgap_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic signed [15:0]  start_x_i,
  input  logic signed [15:0]  start_y_i,
  input  logic [7:0]          text_byte_i,
  input  logic [15:0]         map_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [ADDR_W-1:0]   flash_address_o,
  output logic [LEN_W-1:0]    read_length_o,
  output logic signed [15:0]  draw_x_o,
  output logic signed [15:0]  draw_y_o,
  output logic [7:0]          glyph_size_o,
  output logic [7:0]          char_code_o
);

  cmd_t    cmd;
  status_t status;

  // parse phase, stop flag and beat handshakes
  cgap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // registers, pen, address arithmetic and result payload
  cgap_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .text_byte_i     (text_byte_i),
    .map_word_i      (map_word_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_o          (kind_o),
    .flash_address_o (flash_address_o),
    .read_length_o   (read_length_o),
    .draw_x_o        (draw_x_o),
    .draw_y_o        (draw_y_o),
    .glyph_size_o    (glyph_size_o),
    .char_code_o     (char_code_o)
  );

endmodule

// ----- test/cjk_glyph_address_parser_checker.sv -----
// Checker for the CJK glyph address parser: predicts flash requests and compares results.
module cjk_glyph_address_parser_checker import cgap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        start_x_i,
  input  logic [15:0]        start_y_i,
  input  logic [7:0]         text_byte_i,
  input  logic [15:0]        map_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         kind_i,
  input  logic [ADDR_W-1:0]  flash_address_i,
  input  logic [LEN_W-1:0]   read_length_i,
  input  logic [15:0]        draw_x_i,
  input  logic [15:0]        draw_y_i,
  input  logic [7:0]         glyph_size_i,
  input  logic [7:0]         char_code_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [15:0]       dx;
    logic [15:0]       dy;
    logic [7:0]        size;
    logic [7:0]        code;
  } flash_req_t;

  flash_req_t awaited_reqs[$];
  flash_req_t want, seen;

  // shadow registers
  logic [7:0]        cjk_size, ascii_size;
  logic              mixed;
  logic [ADDR_W-1:0] map_base, font12_base, font16_base, font20_base;

  // shadow parser state
  phase_e      phase;
  logic [7:0]  lead_byte, mid_byte;
  logic [15:0] pen_x, pen_y;
  logic        halted;
  logic [15:0] code_point;

  int unsigned mismatches, checked;

  task automatic queue_req(input kind_e k, input logic [ADDR_W-1:0] a,
                           input logic [LEN_W-1:0] l, input logic [15:0] x,
                           input logic [15:0] y, input logic [7:0] s,
                           input logic [7:0] c);
    awaited_reqs.push_back('{kind: k, addr: a, len: l, dx: x, dy: y, size: s, code: c});
  endtask

  task automatic stop_string(input kind_e k);
    halted = 1'b1;
    phase  = ST_IDLE;
    queue_req(k, '0, '0, '0, '0, '0, '0);
  endtask

  // row/col offsets wrap freely; everything is mod 2^24
  task automatic queue_glyph(input logic [7:0] hi, input logic [7:0] lo);
    logic [ADDR_W-1:0] base, idx;
    logic [LEN_W-1:0]  bytes;
    if (cjk_size == SIZE_SMALL) begin
      base  = font12_base;
      bytes = SMALL_GLYPH_BYTES;
    end else if (cjk_size == SIZE_LARGE) begin
      base  = font20_base;
      bytes = LARGE_GLYPH_BYTES;
    end else begin
      base  = font16_base;
      bytes = MID_GLYPH_BYTES;
    end
    idx = (ADDR_W'(hi) - ADDR_W'(GB_FIRST_BYTE)) * GB_ROW_LEN
        + (ADDR_W'(lo) - ADDR_W'(GB_FIRST_BYTE));
    queue_req(KIND_GLYPH, base + idx * ADDR_W'(bytes), bytes, pen_x, pen_y, cjk_size, '0);
    pen_x = pen_x + 16'(cjk_size);
    phase = ST_IDLE;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cjk_size    = 8'd16;
      ascii_size  = 8'd8;
      mixed       = 1'b1;
      map_base    = '0;
      font12_base = '0;
      font16_base = '0;
      font20_base = '0;
      phase       = ST_IDLE;
      lead_byte   = '0;
      mid_byte    = '0;
      pen_x       = '0;
      pen_y       = '0;
      halted      = 1'b1;
      awaited_reqs.delete();
      mismatches  = 0;
      checked     = 0;
      error_count_o <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      // result side: a result beat always belongs to an earlier input beat
      if (out_valid_i && !out_stall_i) begin
        seen = '{kind: kind_e'(kind_i), addr: flash_address_i, len: read_length_i,
                 dx: draw_x_i, dy: draw_y_i, size: glyph_size_i, code: char_code_i};
        if (awaited_reqs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected result beat kind %0d addr %h", $realtime,
                     kind_i, flash_address_i);
        end else begin
          want = awaited_reqs.pop_front();
          checked++;
          if (seen.kind !== want.kind || seen.addr !== want.addr || seen.len !== want.len ||
              seen.dx !== want.dx || seen.dy !== want.dy || seen.size !== want.size ||
              seen.code !== want.code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: mismatch, expected kind %0d addr %h len %0d x %0d y %0d",
                       $realtime, want.kind, want.addr, want.len, $signed(want.dx),
                       $signed(want.dy));
              $display("    size %0d code %h; got kind %0d addr %h len %0d x %0d y %0d",
                       want.size, want.code, seen.kind, seen.addr, seen.len,
                       $signed(seen.dx), $signed(seen.dy));
              $display("    size %0d code %h", seen.size, seen.code);
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CJK_SIZE:    cjk_size    = cfg_data_i[7:0];
          CFG_ASCII_SIZE:  ascii_size  = cfg_data_i[7:0];
          CFG_MIXED:       mixed       = cfg_data_i[0];
          CFG_MAP_BASE:    map_base    = cfg_data_i;
          CFG_FONT12_BASE: font12_base = cfg_data_i;
          CFG_FONT16_BASE: font16_base = cfg_data_i;
          CFG_FONT20_BASE: font20_base = cfg_data_i;
          default: ;
        endcase
      end

      // input side: predict what this beat causes
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_START) begin
          pen_x  = start_x_i;
          pen_y  = start_y_i;
          halted = 1'b0;
          phase  = ST_IDLE;
        end else if (!halted && operation_i == OP_MAP) begin
          if (phase == ST_MAPW) begin
            if (map_word_i == '0) stop_string(KIND_ERROR);
            else queue_glyph(map_word_i[15:8], map_word_i[7:0]);
          end
        end else if (!halted && operation_i == OP_TEXT) begin
          // NUL ends the string in every phase but the map wait
          if (text_byte_i == '0 && phase != ST_MAPW) begin
            stop_string(KIND_END);
          end else begin
            case (phase)
              ST_IDLE: begin
                if ((text_byte_i & UTF_LEAD_MASK) == UTF_LEAD_CODE) begin
                  lead_byte = text_byte_i;
                  phase     = ST_UTF1;
                end else if (text_byte_i >= GB_FIRST_BYTE) begin
                  lead_byte = text_byte_i;
                  phase     = ST_GB1;
                end else if (mixed) begin
                  queue_req(KIND_ASCII, '0, '0, pen_x, pen_y, ascii_size, text_byte_i);
                  pen_x = pen_x + 16'(ascii_size);
                end
              end
              ST_UTF1: begin
                mid_byte = text_byte_i;
                phase    = ST_UTF2;
              end
              ST_UTF2: begin
                code_point = {lead_byte[3:0], mid_byte[5:0], text_byte_i[5:0]};
                if (code_point < MAP_FIRST_CODE || code_point > MAP_LAST_CODE) begin
                  stop_string(KIND_ERROR);
                end else begin
                  phase = ST_MAPW;
                  queue_req(KIND_MAP,
                            map_base + (ADDR_W'(code_point) - ADDR_W'(MAP_FIRST_CODE))
                                       * ADDR_W'(2),
                            MAP_ENTRY_BYTES, '0, '0, '0, '0);
                end
              end
              ST_GB1: queue_glyph(lead_byte, text_byte_i);
              default: ;
            endcase
          end
        end
      end

      error_count_o <= mismatches;
      pending_o     <= awaited_reqs.size();
      checked_o     <= checked;
    end
  end

endmodule

// ----- test/cjk_glyph_address_parser_tb.sv -----
// Testbench top for the CJK glyph address parser: stimulus, receiver and verdict.
module cjk_glyph_address_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cgap_pkg::*;

  // codes the block must ignore
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

  localparam int unsigned PHASE_BEATS = 280;  // random beats per register setting
  localparam int unsigned HOLD_CYCLES = 400;  // long receiver hold-off

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = '0;
  logic [15:0]        start_x   = '0;
  logic [15:0]        start_y   = '0;
  logic [7:0]         text_byte = '0;
  logic [15:0]        map_word  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         kind;
  logic [ADDR_W-1:0]  flash_address;
  logic [LEN_W-1:0]   read_length;
  logic [15:0]        draw_x, draw_y;
  logic [7:0]         glyph_size, char_code;

  logic               hold_go = 1'b0;

  int unsigned mismatch_count, awaited_count, checked_count;
  int unsigned beats_sent = 0;
  int unsigned settings   = 0;
  int          burst_left = 0;
  bit          need_start = 1'b0;

  always #1 clk_i = ~clk_i;

  cjk_glyph_address_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .text_byte_i     (text_byte),
    .map_word_i      (map_word),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .flash_address_o (flash_address),
    .read_length_o   (read_length),
    .draw_x_o        (draw_x),
    .draw_y_o        (draw_y),
    .glyph_size_o    (glyph_size),
    .char_code_o     (char_code)
  );

  cjk_glyph_address_parser_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .start_x_i       (start_x),
    .start_y_i       (start_y),
    .text_byte_i     (text_byte),
    .map_word_i      (map_word),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .flash_address_i (flash_address),
    .read_length_i   (read_length),
    .draw_x_i        (draw_x),
    .draw_y_i        (draw_y),
    .glyph_size_i    (glyph_size),
    .char_code_i     (char_code),
    .error_count_o   (mismatch_count),
    .pending_o       (awaited_count),
    .checked_o       (checked_count)
  );

  // One input beat. The sender runs in bursts; between bursts valid drops for a
  // random gap. Valid is only lowered when at least one edge follows, so it is
  // never lowered and raised within one step. Returns just after the edge at
  // which the beat was taken.
  task automatic send_beat(input logic [1:0] op, input logic [15:0] sx,
                           input logic [15:0] sy, input logic [7:0] b,
                           input logic [15:0] w);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // an occasional long burst gives stretches with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    start_x   <= sx;
    start_y   <= sy;
    text_byte <= b;
    map_word  <= w;
    do @(posedge clk_i); while (in_stall);
    beats_sent++;
  endtask

  // fields that the operation does not use carry random values
  task automatic send_text(input logic [7:0] b);
    send_beat(OP_TEXT, 16'($urandom), 16'($urandom), b, 16'($urandom));
  endtask

  task automatic send_map(input logic [15:0] w);
    send_beat(OP_MAP, 16'($urandom), 16'($urandom), 8'($urandom), w);
  endtask

  task automatic send_start(input logic [15:0] sx, input logic [15:0] sy);
    send_beat(OP_START, sx, sy, 8'($urandom), 16'($urandom));
    need_start = 1'b0;
  endtask

  // Quiet point: valid low and every result in; it also waits out any beat
  // that gives no result but may still be in the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write; calls run back to back, and the caller lowers the enable after the last.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Register settings per phase. Narrow registers get random junk above their
  // width, which the block must drop.
  task automatic configure(input int p);
    logic [7:0]        cjk, asc;
    logic              mix;
    logic [ADDR_W-1:0] mb, b12, b16, b20;
    cjk = 8'($urandom);
    asc = 8'($urandom);
    mix = 1'($urandom);
    mb  = ADDR_W'($urandom);
    b12 = ADDR_W'($urandom);
    b16 = ADDR_W'($urandom);
    b20 = ADDR_W'($urandom);
    case (p)
      1: begin
        cjk = SIZE_SMALL; asc = 8'd0; mix = 1'b1;
        mb = '1; b12 = '1; b16 = '1; b20 = '1;
      end
      2: begin
        cjk = SIZE_LARGE; asc = 8'd255; mix = 1'b0;
      end
      3: begin
        cjk = 8'd16; mix = 1'b1;
      end
      4: begin
        cjk = 8'd0; asc = 8'd8; mix = 1'b1;
        mb = '0; b12 = '0; b16 = '0; b20 = '0;
      end
      5: begin
        cjk = 8'd255; asc = 8'd255; mix = 1'b1;
        mb = '1; b12 = '1; b16 = '1; b20 = '1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: cjk = SIZE_SMALL;
          1: cjk = SIZE_LARGE;
          2: cjk = 8'd16;
          default: ;
        endcase
      end
    endcase
    write_reg(CFG_CJK_SIZE,    {16'($urandom), cjk});
    write_reg(CFG_ASCII_SIZE,  {16'($urandom), asc});
    write_reg(CFG_MIXED,       {23'($urandom), mix});
    write_reg(CFG_MAP_BASE,    mb);
    write_reg(CFG_FONT12_BASE, b12);
    write_reg(CFG_FONT16_BASE, b16);
    write_reg(CFG_FONT20_BASE, b20);
    // a write to the unused index must change nothing
    if (p == 2) write_reg(CFG_UNUSED_IDX, CFG_W'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // GB2312 pair; mostly well-formed, sometimes a low byte below 0xA1 or a NUL
  task automatic send_gb_pair();
    logic [7:0] hi, lo;
    do hi = 8'($urandom_range(8'hA1, 8'hFF)); while ((hi & UTF_LEAD_MASK) == UTF_LEAD_CODE);
    if ($urandom_range(0, 19) == 0) begin
      lo = 8'h00;
      need_start = 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      lo = 8'($urandom_range(1, 255));
    end else begin
      lo = 8'($urandom_range(8'hA1, 8'hFE));
    end
    send_text(hi);
    send_text(lo);
  endtask

  // UTF-8 three-byte character and, when the code is mapped, its map reply
  task automatic send_utf_char();
    logic [15:0] code;
    logic [7:0]  b2, b3;
    logic [1:0]  top2, top3;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 70) code = 16'($urandom_range(MAP_FIRST_CODE, MAP_LAST_CODE));
    else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: code = MAP_FIRST_CODE - 16'd1;
        1: code = MAP_FIRST_CODE;
        2: code = MAP_LAST_CODE;
        default: code = MAP_LAST_CODE + 16'd1;
      endcase
    end else code = 16'($urandom);
    // continuation markers are not checked; vary them, but never to a NUL
    top2 = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : 2'b10;
    top3 = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : 2'b10;
    b2 = {top2, code[11:6]};
    b3 = {top3, code[5:0]};
    send_text({4'hE, code[15:12]});
    if ($urandom_range(0, 24) == 0) begin
      send_text(8'h00);  // NUL after the lead
      need_start = 1'b1;
      return;
    end
    send_text(b2);
    if ($urandom_range(0, 24) == 0) begin
      send_text(8'h00);  // NUL before the last byte
      need_start = 1'b1;
      return;
    end
    send_text(b3);
    if (code < MAP_FIRST_CODE || code > MAP_LAST_CODE) begin
      need_start = 1'b1;
      return;
    end
    // a stray text beat while the map reply is awaited, sometimes a NUL
    if ($urandom_range(0, 9) == 0)
      send_text(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 85) begin
      send_map({8'($urandom_range(8'hA1, 8'hF7)), 8'($urandom_range(8'hA1, 8'hFE))});
    end else if (r < 93) begin
      send_map(16'h0000);
      need_start = 1'b1;
    end else begin
      send_map(16'($urandom));
    end
  endtask

  // Random part of one phase: mostly whole characters with random content,
  // the rest NULs, stray beats and fresh strings.
  task automatic random_phase(input int unsigned n);
    int unsigned target;
    int          r;
    target = beats_sent + n;
    send_start(16'($urandom), 16'($urandom));
    while (beats_sent < target) begin
      if (need_start || $urandom_range(0, 99) < 5) begin
        if ($urandom_range(0, 4) == 0)
          send_start(($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000,
                     ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
        else
          send_start(16'($urandom), 16'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 28) send_text(8'($urandom_range(1, 8'hA0)));
      else if (r < 53) send_gb_pair();
      else if (r < 85) send_utf_char();
      else if (r < 89) begin
        send_text(8'h00);
        need_start = 1'b1;
      end else if (r < 95) begin
        send_beat(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        send_map(16'($urandom));  // no map reply awaited here
      end
    end
  endtask

  // Receiver: switches between stall patterns of random length, and once
  // holds off for a long stretch so that the result register fills and the
  // input side stalls while the sender keeps offering beats.
  initial begin : receiver
    int          mode;
    int          mode_left;
    int          hold_left;
    bit          hold_done;
    logic [31:0] tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    tick      = '0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= (tick[2:0] == 3'd1) || (tick[2:0] == 3'd6);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset register values.
    send_text(8'h41);                  // still stopped after reset
    send_map(16'h1234);
    send_start(16'h7FFF, 16'h8000);
    send_text(8'h41);                  // drawn at the top of x, pen wraps
    send_text(8'h80);                  // 0x80..0xA0 count as ASCII
    send_text(8'hA0);
    send_map(16'h1234);                // no map read outstanding
    send_beat(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    send_text(8'hA1);                  // first glyph of the table
    send_text(8'hA1);
    send_text(8'hFF);                  // low byte below 0xA1: offsets wrap
    send_text(8'h20);
    send_text(8'hE4);                  // first mapped code point
    send_text(8'hB8);
    send_text(8'h80);
    send_text(8'h41);                  // ignored while the map reply is due
    send_map(16'hFFFF);
    send_text(8'hE9);                  // last mapped code point
    send_text(8'hBE);
    send_text(8'hA5);
    send_map(16'h0000);                // empty map entry: error stop
    send_start(16'h8000, 16'h7FFF);
    send_text(8'hE4);                  // just below the mapped range
    send_text(8'hB7);
    send_text(8'hBF);
    send_start(16'h0000, 16'h0000);
    send_text(8'hE4);                  // NUL inside a character
    send_text(8'h00);
    send_start(16'hFFFF, 16'h0001);
    send_text(8'h00);                  // NUL at the start of a character
    settle();

    // Random part over several register settings.
    for (int p = 1; p <= 7; p++) begin
      configure(p);
      if (p == 3) hold_go <= 1'b1;
      random_phase(PHASE_BEATS);
      settle();
    end

    repeat (20) @(posedge clk_i);
    $display("summary: %0d input beats over %0d register settings, %0d results checked",
             beats_sent, settings + 1, checked_count);
    if (awaited_count != 0) $display("error: %0d results never arrived", awaited_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("timeout with %0d results outstanding", awaited_count);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cgap_pkg.sv
rtl/cgap_ctrl.sv
rtl/cgap_dp.sv
rtl/cjk_glyph_address_parser.sv
test/cjk_glyph_address_parser_checker.sv
test/cjk_glyph_address_parser_tb.sv
